### design/wfpb_pkg.sv
// Shared types, character codes and helpers for the wildcard file name pattern builder.
package wfpb_pkg;

   // Character codes recognized by the classifier and the pattern pass.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_MASK = 8'hDF;

   // Pattern geometry: eight name positions, the dot, three extension positions.
   localparam int POSITIONS = 12;
   localparam int POS_W     = 5;
   localparam logic [POS_W-1:0] NAME_LEN = 5'd8;
   localparam logic [POS_W-1:0] EXT_LEN  = 5'd3;
   localparam logic [3:0] DOT_POS  = 4'd8;
   localparam logic [3:0] EXT_BASE = 4'd9;

   // One input beat.
   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [63:0] name_pattern;
      logic [31:0] ext_pattern;
      logic [11:0] care_mask;
      logic        too_long;
   } rsp_type;

   // A classified character as it waits between the front and the back.
   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
      logic       is_zero;
      logic       is_dot;
      logic       is_star;
   } beat_type;

   // Fold a lower-case letter to upper case; other bytes pass unchanged.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
         r = c & CASE_MASK;
      end
      return r;
   endfunction

endpackage

### design/wfpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfpb_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16,
     localparam int ADDR_W = $clog2(DEPTH))
   (input  logic              clock,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/wfpb_front.sv
// Front end: accepts input beats, classifies each character and queues it for the back end.
module wfpb_front
   import wfpb_pkg::*;
   (input  logic     clock,
    input  logic     reset,
    input  logic     push,
    input  req_type  req_data,
    output logic     full,
    output logic     q_valid,
    output beat_type q_beat,
    input  logic     q_pop);

   // Two-entry queue between front and back.
   beat_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   beat_type   classified;

   // Classify the incoming character.
   always_comb begin
      classified.char_in = req_data.char_in;
      classified.is_last = req_data.is_last;
      classified.is_zero = (req_data.char_in == CH_NUL);
      classified.is_dot  = (req_data.char_in == CH_DOT);
      classified.is_star = (req_data.char_in == CH_STAR);
   end

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_beat  = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### design/wfpb_back.sv
// Back end: stores the name, then walks the stored characters to build pattern and care mask.
module wfpb_back
   import wfpb_pkg::*;
   #(parameter int MAX_CHARS = 16,
     localparam int ADDR_W = $clog2(MAX_CHARS),
     localparam int CNT_W  = $clog2(MAX_CHARS + 1))
   (input  logic     clock,
    input  logic     reset,
    input  logic     q_valid,
    input  beat_type q_beat,
    output logic     q_pop,
    output logic     empty,
    input  logic     pop,
    output rsp_type  rsp_data);

   typedef enum logic [2:0] {ST_LOAD, ST_SETUP, ST_READ, ST_STEP, ST_DONE} state_type;

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] dot_ff, dot_in;
   logic           zero_seen_ff, zero_seen_in;
   logic           dot_seen_ff, dot_seen_in;
   logic           name_star_ff, name_star_in;
   logic           ext_star_ff, ext_star_in;
   logic           overflow_ff, overflow_in;
   logic           part_ff, part_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]     src_ff, src_in;
   logic [7:0]     pat_ff [POSITIONS];
   logic [7:0]     pat_in [POSITIONS];
   logic [11:0]    care_ff, care_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic             ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]       ram_rd_data;

   logic [CNT_W-1:0] nlen, elen, part_len, width_c, skip_c, src_addr;
   logic [POS_W-1:0] part_width, pos_step;
   logic             part_star, src_ok, stored;
   logic [7:0]       cur_char;
   logic [3:0]       wpos;

   // Character store.
   wfpb_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (q_beat.char_in),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data));

   // Part geometry for the walk.
   always_comb begin
      nlen       = dot_seen_ff ? dot_ff : len_ff;
      elen       = len_ff - dot_ff - CNT_W'(1);
      part_len   = part_ff ? elen : nlen;
      part_width = part_ff ? EXT_LEN : NAME_LEN;
      part_star  = part_ff ? ext_star_ff : name_star_ff;
      width_c    = CNT_W'(part_width);
      skip_c     = (part_len < width_c) ? (width_c - part_len) : '0;
      src_ok     = CNT_W'(src_ff) < part_len;
      src_addr   = (part_ff ? (dot_ff + CNT_W'(1)) : '0) + CNT_W'(src_ff);
      cur_char   = src_ok ? ram_rd_data : CH_NUL;
      wpos       = part_ff ? (EXT_BASE + pos_ff[3:0]) : pos_ff[3:0];
      stored     = count_ff < CNT_W'(MAX_CHARS);
   end

   assign ram_rd_addr = src_addr[ADDR_W-1:0];
   assign ram_wr_addr = count_ff[ADDR_W-1:0];
   assign ram_wr_en   = (state_ff == ST_LOAD) && q_valid && stored;
   assign q_pop       = (state_ff == ST_LOAD) && q_valid;

   // Next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      dot_in       = dot_ff;
      zero_seen_in = zero_seen_ff;
      dot_seen_in  = dot_seen_ff;
      name_star_in = name_star_ff;
      ext_star_in  = ext_star_ff;
      overflow_in  = overflow_ff;
      part_in      = part_ff;
      pos_in       = pos_ff;
      src_in       = src_ff;
      pat_in       = pat_ff;
      care_in      = care_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pos_step     = pos_ff + POS_W'(1);

      if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Store beats that fit, flag overflow; track length, first dot and stars per part.
         ST_LOAD: begin
            if (q_valid) begin
               if (stored) begin
                  count_in = count_ff + CNT_W'(1);
                  if (!zero_seen_ff) begin
                     if (q_beat.is_zero) begin
                        zero_seen_in = 1'b1;
                     end else begin
                        len_in = len_ff + CNT_W'(1);
                        if (q_beat.is_dot && !dot_seen_ff) begin
                           dot_seen_in = 1'b1;
                           dot_in      = count_ff;
                        end else if (q_beat.is_star) begin
                           if (dot_seen_ff) begin
                              ext_star_in = 1'b1;
                           end else begin
                              name_star_in = 1'b1;
                           end
                        end
                     end
                  end
               end else begin
                  overflow_in = 1'b1;
               end
               if (q_beat.is_last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         // Clear the pattern and place the dot if there is one.
         ST_SETUP: begin
            for (int k = 0; k < POSITIONS; k++) begin
               pat_in[k] = CH_NUL;
            end
            care_in = '0;
            if (dot_seen_ff) begin
               pat_in[DOT_POS]  = CH_DOT;
               care_in[DOT_POS] = 1'b1;
            end
            part_in  = 1'b0;
            pos_in   = '0;
            src_in   = '0;
            state_in = ST_READ;
         end
         // Wait for the store read.
         ST_READ: begin
            state_in = ST_STEP;
         end
         // One position step of the walk.
         ST_STEP: begin
            if (!part_star) begin
               if (src_ok) begin
                  pat_in[wpos]  = fold_case(cur_char);
                  care_in[wpos] = (cur_char != CH_QUEST);
               end else begin
                  pat_in[wpos]  = CH_SPACE;
                  care_in[wpos] = 1'b1;
               end
            end else if (cur_char == CH_STAR) begin
               pos_step = pos_ff + POS_W'(1) + POS_W'(skip_c);
            end else if (cur_char != CH_QUEST) begin
               pat_in[wpos]  = fold_case(cur_char);
               care_in[wpos] = 1'b1;
            end
            pos_in = pos_step;
            src_in = src_ff + 4'd1;
            if (pos_step >= part_width) begin
               if (!part_ff && dot_seen_ff) begin
                  part_in  = 1'b1;
                  pos_in   = '0;
                  src_in   = '0;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         // Once the output register is free, hand the result to it and start the next name.
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               for (int k = 0; k < 8; k++) begin
                  rsp_data_in.name_pattern[8*k +: 8] = pat_ff[k];
               end
               for (int k = 0; k < 4; k++) begin
                  rsp_data_in.ext_pattern[8*k +: 8] = pat_ff[8 + k];
               end
               rsp_data_in.care_mask = care_ff;
               rsp_data_in.too_long  = overflow_ff
                                       || (nlen > CNT_W'(NAME_LEN))
                                       || (dot_seen_ff && (elen > CNT_W'(EXT_LEN)));
               rsp_valid_in = 1'b1;
               count_in     = '0;
               len_in       = '0;
               dot_in       = '0;
               zero_seen_in = 1'b0;
               dot_seen_in  = 1'b0;
               name_star_in = 1'b0;
               ext_star_in  = 1'b0;
               overflow_in  = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         len_ff       <= '0;
         dot_ff       <= '0;
         zero_seen_ff <= 1'b0;
         dot_seen_ff  <= 1'b0;
         name_star_ff <= 1'b0;
         ext_star_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         part_ff      <= 1'b0;
         pos_ff       <= '0;
         src_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < POSITIONS; k++) begin
            pat_ff[k] <= CH_NUL;
         end
         care_ff      <= '0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         dot_ff       <= dot_in;
         zero_seen_ff <= zero_seen_in;
         dot_seen_ff  <= dot_seen_in;
         name_star_ff <= name_star_in;
         ext_star_ff  <= ext_star_in;
         overflow_ff  <= overflow_in;
         part_ff      <= part_in;
         pos_ff       <= pos_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
         pat_ff       <= pat_in;
         care_ff      <= care_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### design/wildcard_filename_pattern_builder.sv
// A beat that closes a name gives its result after the setup step, up to a read and a place
// step per name position and, if a dot is present, per extension position, and the done step,
// plus any wait for the previous result to be popped. A name loads at one character per cycle
// while the back end loads; each name then adds a read-and-place pattern pass over the store.
// Reset is synchronous and active high; it empties the queue and the result register.
// The character store needs no clearing pass; only characters of the current name are read.
module wildcard_filename_pattern_builder
   import wfpb_pkg::*;
   #(parameter int MAX_CHARS = 16)
   (input  logic    clock,
    input  logic    reset,
    input  logic    push,
    input  req_type req_data,
    output logic    full,
    output logic    empty,
    input  logic    pop,
    output rsp_type rsp_data);

   logic     q_valid;
   logic     q_pop;
   beat_type q_beat;

   // Front end with its beat queue.
   wfpb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .q_valid  (q_valid),
      .q_beat   (q_beat),
      .q_pop    (q_pop));

   // Back end with the character store and the pattern pass.
   wfpb_back #(.MAX_CHARS(MAX_CHARS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_beat   (q_beat),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data));

   // The back end never takes a beat from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   // A full queue always offers a beat to the back end.
   assert property (@(posedge clock) disable iff (reset) full |-> q_valid)
      else $error("queue full while offering no beat");

   // Coming out of reset no result is waiting.
   assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("result present right after reset");

endmodule
